[rtl/scbm_pkg.sv]
// shared types and constants for the codebook best-match search
package scbm_pkg;
  localparam int unsigned MaxEntries = 256;
  localparam int unsigned MaxPiece   = 128;
  localparam int unsigned EntW  = $clog2(MaxEntries);
  localparam int unsigned PosW  = $clog2(MaxPiece);
  localparam int unsigned CbAw  = EntW + PosW;
  localparam int unsigned SumW  = 8 + 1 + PosW + 1 + 1;
  localparam int unsigned QDepth = 2;

  localparam logic CfgPieceSize = 1'b0;
  localparam logic CfgEntries   = 1'b1;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic [PosW:0] piece;
    logic [EntW:0] entries;
    logic [PosW:0] filled;
  } job_t;

  function automatic logic [8:0] abs_diff(logic signed [7:0] a, logic signed [7:0] b);
    logic signed [8:0] d;
    d = 9'(a) - 9'(b);
    return d[8] ? 9'(-d) : d;
  endfunction
endpackage

[rtl/sad_codebook_best_match.sv]
// top level of the codebook best-match search
//   channel | direction | handshake     | payload
//   in      | input     | valid / stall | op entry position left right flush
//   out     | output    | valid / stall | best_entry best_score
//   cfg     | input     | write enable  | index, 9-bit data
// a completed piece makes the back end read every in-use entry over the piece,
// one codebook ram read per cycle; input stalls while the search runs.
// reset clears fill count and control, sets piece 100, entries 1; ram undefined.
// a pending result holds until out stall drops; input keeps flowing meanwhile
// until the next piece completes, which then waits for the result to leave.
module sad_codebook_best_match import scbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        op_i,
  input  logic [7:0]  entry_i,
  input  logic [6:0]  position_i,
  input  logic [7:0]  left_i,
  input  logic [7:0]  right_i,
  input  logic        flush_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  best_entry_o,
  output logic [15:0] best_score_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  logic [7:0] piece_size_q;
  logic [8:0] entries_q;
  logic cb_we, q_we, jv_f, js_f, jv_b, js_b, busy;
  logic [CbAw-1:0] cb_wa, cb_ra;
  logic [PosW-1:0] q_wa, q_ra;
  logic [15:0] wd, cb_rd, q_rd;
  job_t job_f, job_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piece_size_q <= 8'd100;
      entries_q    <= 9'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPieceSize: piece_size_q <= cfg_data_i[7:0];
        CfgEntries:   entries_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  scbm_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .op_i, .entry_i, .position_i,
    .left_i, .right_i, .flush_i,
    .piece_size_i(piece_size_q), .entries_in_use_i(entries_q),
    .back_busy_i(busy || jv_b),
    .cb_we_o(cb_we), .cb_waddr_o(cb_wa), .q_we_o(q_we), .q_waddr_o(q_wa),
    .wdata_o(wd), .job_valid_o(jv_f), .job_stall_i(js_f), .job_o(job_f)
  );

  scbm_job_fifo u_fifo (
    .clk_i, .rst_ni, .valid_i(jv_f), .stall_o(js_f), .data_i(job_f),
    .valid_o(jv_b), .stall_i(js_b), .data_o(job_b)
  );

  scbm_ram #(.Width(16), .Depth(MaxEntries*MaxPiece)) u_cb_ram (
    .clk_i, .we_i(cb_we), .waddr_i(cb_wa), .wdata_i(wd),
    .raddr_i(cb_ra), .rdata_o(cb_rd)
  );

  scbm_ram #(.Width(16), .Depth(MaxPiece)) u_q_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(wd),
    .raddr_i(q_ra), .rdata_o(q_rd)
  );

  scbm_back u_back (
    .clk_i, .rst_ni, .job_valid_i(jv_b), .job_stall_o(js_b), .job_i(job_b),
    .busy_o(busy), .cb_raddr_o(cb_ra), .cb_rdata_i(cb_rd),
    .q_raddr_o(q_ra), .q_rdata_i(q_rd),
    .valid_o, .stall_i, .best_entry_o, .best_score_o
  );
endmodule

[rtl/scbm_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module scbm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/scbm_front.sv]
// front end: classifies items, fills query piece, issues search jobs
module scbm_front import scbm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  logic            op_i,
  input  logic [7:0]      entry_i,
  input  logic [6:0]      position_i,
  input  logic [7:0]      left_i,
  input  logic [7:0]      right_i,
  input  logic            flush_i,
  input  logic [7:0]      piece_size_i,
  input  logic [8:0]      entries_in_use_i,
  input  logic            back_busy_i,
  output logic            cb_we_o,
  output logic [CbAw-1:0] cb_waddr_o,
  output logic            q_we_o,
  output logic [PosW-1:0] q_waddr_o,
  output logic [15:0]     wdata_o,
  output logic            job_valid_o,
  input  logic            job_stall_i,
  output job_t            job_o
);
  logic [7:0]    fill_q, fill_d;
  logic [PosW:0] ps;
  logic [EntW:0] ne;
  logic          acc, done;

  always_comb begin
    if (piece_size_i == 8'd0) ps = (PosW+1)'(1);
    else if (32'(piece_size_i) > MaxPiece) ps = (PosW+1)'(MaxPiece);
    else ps = (PosW+1)'(piece_size_i);
    if (entries_in_use_i == 9'd0) ne = (EntW+1)'(1);
    else if (32'(entries_in_use_i) > MaxEntries) ne = (EntW+1)'(MaxEntries);
    else ne = (EntW+1)'(entries_in_use_i);
  end

  // a query that completes a piece needs room in the job queue and a quiet back end
  assign done = op_i == OpQuery && ((32'(fill_q) + 1 >= 32'(ps)) || flush_i);
  assign stall_o = back_busy_i || (done && job_stall_i);
  assign acc = valid_i && !stall_o;

  assign wdata_o    = {left_i, right_i};
  assign cb_we_o    = acc && op_i == OpLoad && 32'(entry_i) < MaxEntries
                      && 32'(position_i) < MaxPiece;
  assign cb_waddr_o = {entry_i[EntW-1:0], position_i[PosW-1:0]};
  assign q_we_o     = acc && op_i == OpQuery && 32'(fill_q) < MaxPiece;
  assign q_waddr_o  = fill_q[PosW-1:0];

  assign job_valid_o   = acc && done;
  assign job_o.piece   = ps;
  assign job_o.entries = ne;
  assign job_o.filled  = (PosW+1)'(32'(fill_q) + 1 > MaxPiece ? MaxPiece : 32'(fill_q) + 1);

  always_comb begin
    fill_d = fill_q;
    if (acc && op_i == OpQuery) fill_d = done ? 8'd0 : fill_q + 8'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end
endmodule

[rtl/scbm_back.sv]
// back end: walks codebook entries, accumulates sad, keeps running best
module scbm_back import scbm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_stall_o,
  input  job_t            job_i,
  output logic            busy_o,
  output logic [CbAw-1:0] cb_raddr_o,
  input  logic [15:0]     cb_rdata_i,
  output logic [PosW-1:0] q_raddr_o,
  input  logic [15:0]     q_rdata_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic [7:0]      best_entry_o,
  output logic [15:0]     best_score_o
);
  job_t            job_q;
  logic            run_q;
  logic [EntW-1:0] e_q;
  logic [PosW-1:0] i_q;
  logic            rv_q, rlast_q, rzero_q;
  logic [EntW-1:0] re_q;
  logic [SumW-1:0] sum_q, best_q;
  logic [EntW-1:0] bent_q;
  logic            ov_q;
  logic            last_i, last_e, fin;
  logic [8:0]      dl, dr;
  logic [SumW-1:0] nsum;
  logic [15:0]     qv;

  // a waiting result only holds back the next job, not the front end
  assign busy_o      = run_q || rv_q;
  assign job_stall_o = run_q || rv_q || ov_q;
  assign cb_raddr_o  = {e_q, i_q};
  assign q_raddr_o   = i_q;
  assign last_i = 32'(i_q) + 1 >= 32'(job_q.piece);
  assign last_e = 32'(e_q) + 1 >= 32'(job_q.entries);

  assign qv   = rzero_q ? 16'd0 : q_rdata_i;
  assign dl   = abs_diff(cb_rdata_i[15:8], qv[15:8]);
  assign dr   = abs_diff(cb_rdata_i[7:0], qv[7:0]);
  assign nsum = sum_q + SumW'(dl) + SumW'(dr);
  assign fin  = rv_q && rlast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      rv_q  <= 1'b0;
      ov_q  <= 1'b0;
      e_q   <= '0;
      i_q   <= '0;
    end else begin
      rv_q <= run_q;
      if (!run_q && !rv_q && !ov_q && job_valid_i) begin
        run_q <= 1'b1;
        e_q   <= '0;
        i_q   <= '0;
      end else if (run_q) begin
        if (last_i) begin
          i_q <= '0;
          if (last_e) run_q <= 1'b0;
          else e_q <= e_q + 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
      if (fin && re_q == EntW'(job_q.entries - 1'b1)) ov_q <= 1'b1;
      else if (ov_q && !stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!run_q && !rv_q && !ov_q && job_valid_i) job_q <= job_i;
    rlast_q <= last_i;
    rzero_q <= 32'(i_q) >= 32'(job_q.filled);
    re_q    <= e_q;
    if (rv_q) begin
      sum_q <= rlast_q ? '0 : nsum;
      if (rlast_q && (re_q == '0 || nsum < best_q)) begin
        best_q <= nsum;
        bent_q <= re_q;
      end
    end else begin
      sum_q <= '0;
    end
  end

  assign valid_o      = ov_q;
  assign best_entry_o = 8'(bent_q);
  assign best_score_o = best_q > SumW'(16'hFFFF) ? 16'hFFFF : 16'(best_q);
endmodule

[rtl/scbm_job_fifo.sv]
// short job queue between front and back
module scbm_job_fifo import scbm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic stall_o,
  input  job_t data_i,
  output logic valid_o,
  input  logic stall_i,
  output job_t data_o
);
  job_t        mem_q [QDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign stall_o = cnt_q == 2'(QDepth);
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];
  assign push = valid_i && !stall_o;
  assign pop  = valid_o && !stall_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

[rtl/scbm_checker.sv]
// port-level checker for the best-match search, bound to the top level
module scbm_checker import scbm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        op_i,
  input logic        valid_o,
  input logic        stall_i,
  input logic [7:0]  best_entry_o,
  input logic [15:0] best_score_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(best_score_o) && $stable(best_entry_o))
    else $error("result changed while stalled");
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o && op_i == OpLoad && !valid_o |=> !valid_o)
    else $error("load produced a result");
  a_result_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i |=> !valid_o)
    else $error("result repeated");
endmodule

bind sad_codebook_best_match scbm_checker u_checker (
  .clk_i, .rst_ni, .valid_i, .stall_o, .op_i, .valid_o, .stall_i,
  .best_entry_o, .best_score_o
);

[bench/tb_sad_codebook_best_match.sv]
// self-checking testbench for the codebook best-match search block
module tb_sad_codebook_best_match import scbm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 4000000;

  typedef struct {
    logic       op;
    logic [7:0] entry;
    logic [6:0] pos;
    logic [7:0] left;
    logic [7:0] right;
    logic       flush;
  } word_t;

  typedef struct {
    logic [7:0]  entry;
    logic [15:0] score;
  } match_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic        op_i = 1'b0;
  logic [7:0]  entry_i = '0;
  logic [6:0]  position_i = '0;
  logic [7:0]  left_i = '0;
  logic [7:0]  right_i = '0;
  logic        flush_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [7:0]  best_entry_o;
  logic [15:0] best_score_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [8:0]  cfg_data_i = '0;

  sad_codebook_best_match u_dut (.*);

  word_t       pending_words[$];
  match_t      expected_matches[$];
  logic [15:0] codebook[MaxEntries*MaxPiece];
  bit          written[MaxEntries*MaxPiece];
  logic [15:0] query_buf[MaxPiece];
  int unsigned fill_cnt = 0;
  logic [7:0]  piece_reg = 8'd100;
  logic [8:0]  entries_reg = 9'd1;
  int unsigned tx_idle = 9, rx_idle = 53;
  bit          hold_req = 1'b0;
  int unsigned errors = 0, cycles = 0, loads = 0, queries = 0, matched = 0;
  logic        in_fire = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_piece();
    if (piece_reg == 0) return 1;
    if (piece_reg > MaxPiece) return MaxPiece;
    return piece_reg;
  endfunction

  function automatic int unsigned eff_entries();
    if (entries_reg == 0) return 1;
    if (entries_reg > MaxEntries) return MaxEntries;
    return entries_reg;
  endfunction

  function automatic int unsigned dist8(logic [7:0] a, logic [7:0] b);
    int d;
    d = int'($signed(a)) - int'($signed(b));
    return d < 0 ? -d : d;
  endfunction

  task automatic search_word(input word_t w);
    int unsigned ps, n, sum, best, best_sum;
    logic [15:0] c, q;
    match_t m;
    if (w.op == OpLoad) begin
      codebook[w.entry*MaxPiece + w.pos] = {w.left, w.right};
      loads++;
      return;
    end
    queries++;
    ps = eff_piece();
    if (fill_cnt < MaxPiece) query_buf[fill_cnt] = {w.left, w.right};
    fill_cnt++;
    if (fill_cnt < ps && !w.flush) return;
    n = eff_entries();
    best = 0;
    best_sum = 0;
    for (int unsigned e = 0; e < n; e++) begin
      sum = 0;
      for (int unsigned i = 0; i < ps; i++) begin
        c = codebook[e*MaxPiece + i];
        q = (i < fill_cnt) ? query_buf[i] : 16'h0;
        sum += dist8(c[15:8], q[15:8]) + dist8(c[7:0], q[7:0]);
      end
      if (e == 0 || sum < best_sum) begin
        best_sum = sum;
        best = e;
      end
    end
    fill_cnt = 0;
    m.entry = best[7:0];
    m.score = best_sum > 65535 ? 16'hffff : best_sum[15:0];
    expected_matches = {expected_matches, m};
  endtask

  // sampling, prediction and checking
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
    in_fire <= valid_i && !stall_o;
    if (rst_ni && valid_i && !stall_o)
      search_word('{op_i, entry_i, position_i, left_i, right_i, flush_i});
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_matches.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: entry %0d score %0d",
                                   best_entry_o, best_score_o);
      end else begin
        match_t m;
        m = expected_matches.pop_front();
        matched++;
        if (m.entry !== best_entry_o || m.score !== best_score_o) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected entry %0d score %0d, got %0d %0d",
                                     m.entry, m.score, best_entry_o, best_score_o);
        end
      end
    end
  end

  // sender
  always @(negedge clk_i) begin
    word_t w;
    if (rst_ni && !(valid_i && !in_fire)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= tx_idle) begin
        w = pending_words.pop_front();
        valid_i    <= 1'b1;
        op_i       <= w.op;
        entry_i    <= w.entry;
        position_i <= w.pos;
        left_i     <= w.left;
        right_i    <= w.right;
        flush_i    <= w.flush;
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // receiver
  int unsigned hold_left = 0;
  bit          hold_taken = 1'b0;
  always @(negedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_i <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(99) < rx_idle);
    end
  end

  function automatic logic [7:0] rand_sample();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'h80 : 8'h7f;
    return 8'($urandom);
  endfunction

  task automatic push_load(input int unsigned e, input int unsigned p,
                           input logic [7:0] l, input logic [7:0] r);
    word_t w;
    w = '{OpLoad, 8'(e), 7'(p), l, r, 1'($urandom)};
    written[e*MaxPiece + p] = 1'b1;
    pending_words = {pending_words, w};
  endtask

  task automatic push_query(input logic [7:0] l, input logic [7:0] r, input logic fl);
    word_t w;
    w = '{OpQuery, 8'($urandom), 7'($urandom), l, r, fl};
    pending_words = {pending_words, w};
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || valid_i || expected_matches.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [8:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == CfgPieceSize) piece_reg = data[7:0];
    else entries_reg = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic fill_codebook();
    for (int unsigned e = 0; e < eff_entries(); e++)
      for (int unsigned p = 0; p < eff_piece(); p++)
        if (!written[e*MaxPiece + p]) push_load(e, p, rand_sample(), rand_sample());
  endtask

  task automatic random_words(input int unsigned cnt);
    for (int unsigned k = 0; k < cnt; k++) begin
      if ($urandom_range(99) < 25) begin
        if ($urandom_range(9) == 0)
          push_load($urandom_range(MaxEntries-1), $urandom_range(MaxPiece-1),
                    rand_sample(), rand_sample());
        else
          push_load($urandom_range(eff_entries()-1), $urandom_range(eff_piece()-1),
                    rand_sample(), rand_sample());
      end else begin
        push_query(rand_sample(), rand_sample(), $urandom_range(9) == 0);
      end
    end
  endtask

  logic [8:0] ps_list[10] = '{9'd4, 9'd1, 9'd128, 9'd0, 9'd200, 9'd2, 9'd5, 9'd16, 9'd3, 9'd8};
  logic [8:0] en_list[10] = '{9'd3, 9'd256, 9'd1, 9'd0, 9'd2, 9'd511, 9'd16, 9'd8, 9'd40, 9'd12};

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults
    fill_codebook();
    random_words(40);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) begin
        tx_idle = 53;
        rx_idle = 9;
      end else if (ph == 7) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      write_cfg(CfgPieceSize, ps_list[ph]);
      write_cfg(CfgEntries, en_list[ph]);
      fill_codebook();
      if (ph == 0) begin
        // tied entries, extreme samples, early flush, far corner of the store
        for (int unsigned p = 0; p < 4; p++) begin
          push_load(0, p, 8'h7f, 8'h80);
          push_load(1, p, 8'h7f, 8'h80);
        end
        push_load(255, 127, 8'h80, 8'h7f);
        for (int unsigned p = 0; p < 4; p++) push_query(8'h7f, 8'h80, 1'b0);
        for (int unsigned p = 0; p < 4; p++) push_query(8'h80, 8'h7f, 1'b0);
        push_query(8'h80, 8'h80, 1'b1);
        push_query(8'h00, 8'hff, 1'b0);
        push_query(8'h7f, 8'h7f, 1'b1);
      end
      if (ph == 1) hold_req = 1'b1;
      random_words(ph == 2 ? 60 : 40);
      drain();
    end

    errors += expected_matches.size();
    $display("ran %0d loads and %0d query samples over 11 register settings,", loads, queries);
    $display("checked %0d best-match words under varied idle and stall patterns", matched);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/scbm_pkg.sv
rtl/scbm_ram.sv
rtl/scbm_front.sv
rtl/scbm_back.sv
rtl/scbm_job_fifo.sv
rtl/sad_codebook_best_match.sv
rtl/scbm_checker.sv
bench/tb_sad_codebook_best_match.sv
